// ----- design/djt_pkg.sv -----
package djt_pkg;

   localparam int COORD_BITS_DEF  = 12;
   localparam int FINGER_BITS_DEF = 4;

   // fixed datapath widths, sized for the widest coordinate setting
   localparam int AX_W   = 16;
   localparam int SQ_W   = 32;
   localparam int D2_W   = 34;
   localparam int R2_W   = 24;
   localparam int MUL_W  = 24;
   localparam int NUM_W  = 64;
   localparam int DEN_W  = 34;
   localparam int QUO_W  = 31;
   localparam int RAD_W  = 32;
   localparam int ACC_W  = 57;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] REG_DEAD_ZONE = 3'd0;
   localparam logic [2:0] REG_RADIUS    = 3'd1;
   localparam logic [2:0] REG_FIXED     = 3'd2;
   localparam logic [2:0] REG_SCREEN_W  = 3'd3;
   localparam logic [2:0] REG_LEFT_CX   = 3'd4;
   localparam logic [2:0] REG_CENTRE_Y  = 3'd5;
   localparam logic [2:0] REG_R_INSET   = 3'd6;

   localparam logic [11:0] DEAD_ZONE_RST = 12'd10;
   localparam logic [11:0] RADIUS_RST    = 12'd50;
   localparam logic        FIXED_RST     = 1'b1;
   localparam logic [12:0] SCREEN_W_RST  = 13'd1920;
   localparam logic [11:0] LEFT_CX_RST   = 12'd200;
   localparam logic [11:0] CENTRE_Y_RST  = 12'd600;
   localparam logic [11:0] R_INSET_RST   = 12'd200;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_MOVE  = 2'd1;
   localparam logic [1:0] MODE_END   = 2'd2;
   localparam logic [1:0] MODE_KBD   = 2'd3;

   localparam logic [15:0]     ONE_Q15 = 16'h8000;
   localparam logic [D2_W-1:0] ONE_SQ  = D2_W'(1) << 30;

   typedef enum logic {
      OP_DIV  = 1'b0,
      OP_SQRT = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_req_type;

   typedef struct packed {
      logic done;
      logic busy;
   } arith_rsp_type;

   function automatic logic [15:0] sat_q15(input logic [RAD_W-1:0] q, input logic neg);
      logic [RAD_W-1:0] qq;
      qq = (q > RAD_W'(32768)) ? RAD_W'(32768) : q;
      if (neg) begin
         return 16'(17'h10000 - 17'(qq));
      end
      return (q > RAD_W'(32767)) ? 16'h7fff : q[15:0];
   endfunction

endpackage

// ----- design/djt_if.sv -----
interface djt_req_if #(
   parameter int COORD_BITS  = djt_pkg::COORD_BITS_DEF,
   parameter int FINGER_BITS = djt_pkg::FINGER_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             mode;
   logic [FINGER_BITS-1:0] finger_id;
   logic [COORD_BITS-1:0]  touch_x;
   logic [COORD_BITS-1:0]  touch_y;
   logic signed [15:0]     axis_x;
   logic signed [15:0]     axis_y;
   logic                   right_stick;

   modport source (output valid, mode, finger_id, touch_x, touch_y, axis_x, axis_y,
                   right_stick, input ready);
   modport sink   (input valid, mode, finger_id, touch_x, touch_y, axis_x, axis_y,
                   right_stick, output ready);
endinterface

interface djt_rsp_if;
   logic               valid;
   logic               ready;
   logic               stick;
   logic               changed;
   logic signed [15:0] vec_x;
   logic signed [15:0] vec_y;
   logic [15:0]        magnitude;
   logic               pressed;

   modport source (output valid, stick, changed, vec_x, vec_y, magnitude, pressed,
                   input ready);
   modport sink   (input valid, stick, changed, vec_x, vec_y, magnitude, pressed,
                   output ready);
endinterface

// ----- design/djt_arith.sv -----
module djt_arith (
   input  logic                         clock,
   input  logic                         reset,
   input  djt_pkg::arith_req_type       ctl,
   input  logic [djt_pkg::NUM_W-1:0]    num,
   input  logic [djt_pkg::DEN_W-1:0]    den,
   input  logic [djt_pkg::RAD_W-1:0]    rad,
   output djt_pkg::arith_rsp_type       sts,
   output logic [djt_pkg::RAD_W-1:0]    result
);
   import djt_pkg::*;

   localparam logic [4:0] DIV_LAST  = 5'(QUO_W - 1);
   localparam logic [4:0] SQRT_LAST = 5'(RAD_W / 2 - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   arith_op_type       op_ff, op_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   lo_ff, lo_in;
   logic [QUO_W-1:0]   q_ff, q_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [RAD_W-1:0]   v_ff, v_in;
   logic [RAD_W-1:0]   r_ff, r_in;
   logic [RAD_W-1:0]   bit_ff, bit_in;

   logic [DEN_W:0]     trial, diff;
   logic               ge;
   logic [RAD_W:0]     rb;
   logic               sge;

   assign trial = {rem_ff, lo_ff[QUO_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};
   assign rb    = (RAD_W+1)'(r_ff) + (RAD_W+1)'(bit_ff);
   assign sge   = (RAD_W+1)'(v_ff) >= rb;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = '0;
         // quotient stays below 2^QUO_W, so the top part is already below den
         rem_in  = DEN_W'(num >> QUO_W);
         lo_in   = num[QUO_W-1:0];
         q_in    = '0;
         den_in  = den;
         v_in    = rad;
         r_in    = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 2);
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 5'd1;
         if (op_ff == OP_DIV) begin
            lo_in = {lo_ff[QUO_W-2:0], 1'b0};
            q_in  = {q_ff[QUO_W-2:0], ge};
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            if (cnt_ff == DIV_LAST) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            if (sge) begin
               v_in = v_ff - rb[RAD_W-1:0];
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (cnt_ff == SQRT_LAST) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign sts.done = done_ff;
   assign sts.busy = busy_ff;
   assign result   = (op_ff == OP_DIV) ? RAD_W'(q_ff) : r_ff;

endmodule

// ----- design/dual_touch_joystick_tracker_core.sv -----
// Touch start, touch end and ignored items pass from ST_EVT straight to ST_OUT.
// Touch move: no divide in the dead zone, else a divide per axis, then a root per axis
// if clamped or a magnitude divide and root if not; keyboard: a root in range, else as clamped.
// The time is set by the shared divide/root unit, which starts, then yields one result
// bit per cycle until done, plus the multiply and compare steps.
// One item at a time: the next item can be taken in the cycle after the result is loaded.
// Synchronous active-high reset clears both sticks and loads register defaults.
module dual_touch_joystick_tracker_core #(
   parameter int COORD_BITS  = djt_pkg::COORD_BITS_DEF,
   parameter int FINGER_BITS = djt_pkg::FINGER_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [djt_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [djt_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [djt_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   djt_req_if.sink                      req_ch,
   djt_rsp_if.source                    rsp_ch
);
   import djt_pkg::*;

   localparam int CMAX = (1 << COORD_BITS) - 1;

   typedef enum logic [17:0] {
      ST_IDLE = 18'h00001,
      ST_EVT  = 18'h00002,
      ST_SQX  = 18'h00004,
      ST_SQY  = 18'h00008,
      ST_DZ2  = 18'h00010,
      ST_RR2  = 18'h00020,
      ST_DEC  = 18'h00040,
      ST_DIVX = 18'h00080,
      ST_SQTX = 18'h00100,
      ST_DIVY = 18'h00200,
      ST_SQTY = 18'h00400,
      ST_DIVM = 18'h00800,
      ST_SQTM = 18'h01000,
      ST_PLO  = 18'h02000,
      ST_PHI  = 18'h04000,
      ST_PCMP = 18'h08000,
      ST_WRB  = 18'h10000,
      ST_OUT  = 18'h20000
   } state_type;

   function automatic logic [COORD_BITS-1:0] sat_c(input logic [12:0] v);
      if (32'(v) > CMAX) begin
         return COORD_BITS'(CMAX);
      end
      return COORD_BITS'(v);
   endfunction

   // configuration registers
   logic [11:0] dz_ff, sr_ff, lcx_ff, cy_ff, ri_ff;
   logic        fo_ff;
   logic [12:0] sw_ff;
   logic        wr_en;
   logic [11:0] rad_r;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign rad_r      = (sr_ff == 12'd0) ? 12'd1 : sr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff  <= DEAD_ZONE_RST;
         sr_ff  <= RADIUS_RST;
         fo_ff  <= FIXED_RST;
         sw_ff  <= SCREEN_W_RST;
         lcx_ff <= LEFT_CX_RST;
         cy_ff  <= CENTRE_Y_RST;
         ri_ff  <= R_INSET_RST;
      end else if (wr_en) begin
         case (csr_paddr[4:2])
            REG_DEAD_ZONE: dz_ff  <= csr_pwdata[11:0];
            REG_RADIUS:    sr_ff  <= csr_pwdata[11:0];
            REG_FIXED:     fo_ff  <= csr_pwdata[0];
            REG_SCREEN_W:  sw_ff  <= csr_pwdata[12:0];
            REG_LEFT_CX:   lcx_ff <= csr_pwdata[11:0];
            REG_CENTRE_Y:  cy_ff  <= csr_pwdata[11:0];
            REG_R_INSET:   ri_ff  <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_DEAD_ZONE: csr_prdata = DATA_W'(dz_ff);
         REG_RADIUS:    csr_prdata = DATA_W'(sr_ff);
         REG_FIXED:     csr_prdata = DATA_W'(fo_ff);
         REG_SCREEN_W:  csr_prdata = DATA_W'(sw_ff);
         REG_LEFT_CX:   csr_prdata = DATA_W'(lcx_ff);
         REG_CENTRE_Y:  csr_prdata = DATA_W'(cy_ff);
         REG_R_INSET:   csr_prdata = DATA_W'(ri_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // sequencer and stick state
   state_type              state_ff, state_in;
   logic                   issued_ff, issued_in;

   logic [1:0]             mode_ff;
   logic [FINGER_BITS-1:0] fid_ff;
   logic [COORD_BITS-1:0]  tx_ff, ty_ff;
   logic [15:0]            axx_ff, axy_ff;
   logic                   rs_ff;

   logic                   s_ff, s_in;
   logic                   kbd_ff, kbd_in;
   logic                   clamp_ff, clamp_in;
   logic                   nx_ff, nx_in, ny_ff, ny_in;
   logic [AX_W-1:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic [SQ_W-1:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [D2_W-1:0]        d2_ff, d2_in;
   logic [R2_W-1:0]        dz2_ff, dz2_in, r2_ff, r2_in;
   logic [2*MUL_W-1:0]     plo_ff, plo_in, phi_ff, phi_in;
   logic [15:0]            vx_ff, vx_in, vy_ff, vy_in, mag_ff, mag_in;
   logic                   pr_ff, pr_in;
   logic                   out_s_ff, out_s_in, out_chg_ff, out_chg_in;

   logic [1:0]             act_ff, act_in, spr_ff, spr_in;
   logic [FINGER_BITS-1:0] fng_ff [2];
   logic [FINGER_BITS-1:0] fng_in [2];
   logic [COORD_BITS-1:0]  orgx_ff [2];
   logic [COORD_BITS-1:0]  orgx_in [2];
   logic [COORD_BITS-1:0]  orgy_ff [2];
   logic [COORD_BITS-1:0]  orgy_in [2];
   logic [15:0]            svx_ff [2];
   logic [15:0]            svx_in [2];
   logic [15:0]            svy_ff [2];
   logic [15:0]            svy_in [2];
   logic [15:0]            smag_ff [2];
   logic [15:0]            smag_in [2];

   logic                   rsp_v_ff, rsp_v_in;
   logic                   rsp_stick_ff, rsp_chg_ff, rsp_pr_ff;
   logic [15:0]            rsp_vx_ff, rsp_vy_ff, rsp_mag_ff;
   logic                   rsp_load;

   // shared multiplier and divide/root unit
   logic [MUL_W-1:0]       mul_a, mul_b;
   logic [2*MUL_W-1:0]     prod;
   arith_req_type          a_req;
   arith_rsp_type          a_rsp;
   logic                   a_start;
   arith_op_type           a_op;
   logic [NUM_W-1:0]       a_num;
   logic [DEN_W-1:0]       a_den;
   logic [RAD_W-1:0]       a_rad, a_res;

   logic                   half;
   logic [12:0]            rx_c;
   logic                   hit0, hit1, own_s;
   logic [COORD_BITS-1:0]  org_x, org_y;
   logic [D2_W-1:0]        mm;
   logic [ACC_W-1:0]       acc, thr;

   assign prod  = mul_a * mul_b;
   assign half  = ((17'(tx_ff) << 1) < 17'(sw_ff)) ? 1'b0 : 1'b1;
   assign rx_c  = (sw_ff > {1'b0, ri_ff}) ? (sw_ff - {1'b0, ri_ff}) : 13'd0;
   assign hit0  = act_ff[0] && (fng_ff[0] == fid_ff);
   assign hit1  = act_ff[1] && (fng_ff[1] == fid_ff);
   assign own_s = !hit0;
   assign org_x = orgx_ff[own_s];
   assign org_y = orgy_ff[own_s];
   assign mm    = (d2_ff > ONE_SQ) ? ONE_SQ : d2_ff;
   assign acc   = ACC_W'(plo_ff) + (ACC_W'(phi_ff) << 16);
   assign thr   = ACC_W'(dz2_ff) << 30;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_v_ff || rsp_ch.ready);
   assign a_req = '{start: a_start, op: a_op};

   assign req_ch.ready = (state_ff == ST_IDLE);

   djt_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (a_req),
      .num    (a_num),
      .den    (a_den),
      .rad    (a_rad),
      .sts    (a_rsp),
      .result (a_res)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQX: begin
            mul_a = MUL_W'(ax_ff);
            mul_b = MUL_W'(ax_ff);
         end
         ST_SQY: begin
            mul_a = MUL_W'(ay_ff);
            mul_b = MUL_W'(ay_ff);
         end
         ST_DZ2: begin
            mul_a = MUL_W'(dz_ff);
            mul_b = MUL_W'(dz_ff);
         end
         ST_RR2: begin
            mul_a = MUL_W'(rad_r);
            mul_b = MUL_W'(rad_r);
         end
         ST_PLO: begin
            mul_a = MUL_W'(mm[15:0]);
            mul_b = r2_ff;
         end
         ST_PHI: begin
            mul_a = MUL_W'(mm[30:16]);
            mul_b = r2_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      a_num = '0;
      a_den = '0;
      a_rad = a_res;
      a_op  = OP_DIV;
      case (state_ff)
         ST_DIVX: begin
            a_num = clamp_ff ? (NUM_W'(sqx_ff) << 30) : (NUM_W'(ax_ff) << 15);
            a_den = clamp_ff ? d2_ff : DEN_W'(rad_r);
         end
         ST_DIVY: begin
            a_num = clamp_ff ? (NUM_W'(sqy_ff) << 30) : (NUM_W'(ay_ff) << 15);
            a_den = clamp_ff ? d2_ff : DEN_W'(rad_r);
         end
         ST_DIVM: begin
            a_num = NUM_W'(d2_ff) << 30;
            a_den = DEN_W'(r2_ff);
         end
         ST_SQTX, ST_SQTY: a_op = OP_SQRT;
         ST_SQTM: begin
            a_op = OP_SQRT;
            // keyboard in range takes the root of the squared length directly
            if (kbd_ff) begin
               a_rad = d2_ff[RAD_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      a_start    = 1'b0;
      state_in   = state_ff;
      issued_in  = issued_ff;
      s_in       = s_ff;
      kbd_in     = kbd_ff;
      clamp_in   = clamp_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      sqx_in     = sqx_ff;
      sqy_in     = sqy_ff;
      d2_in      = d2_ff;
      dz2_in     = dz2_ff;
      r2_in      = r2_ff;
      plo_in     = plo_ff;
      phi_in     = phi_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      mag_in     = mag_ff;
      pr_in      = pr_ff;
      out_s_in   = out_s_ff;
      out_chg_in = out_chg_ff;
      act_in     = act_ff;
      spr_in     = spr_ff;
      fng_in     = fng_ff;
      orgx_in    = orgx_ff;
      orgy_in    = orgy_ff;
      svx_in     = svx_ff;
      svy_in     = svy_ff;
      smag_in    = smag_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_EVT;
            end
         end
         ST_EVT: begin
            state_in = ST_OUT;
            case (mode_ff)
               MODE_START: begin
                  out_s_in = half;
                  if (act_ff[half]) begin
                     out_chg_in = 1'b0;
                  end else begin
                     out_chg_in   = 1'b1;
                     act_in[half] = 1'b1;
                     fng_in[half] = fid_ff;
                     spr_in[half] = 1'b1;
                     if (fo_ff) begin
                        orgx_in[half] = half ? sat_c(rx_c) : sat_c({1'b0, lcx_ff});
                        orgy_in[half] = sat_c({1'b0, cy_ff});
                     end else begin
                        orgx_in[half] = tx_ff;
                        orgy_in[half] = ty_ff;
                     end
                  end
               end
               MODE_KBD: begin
                  s_in   = rs_ff;
                  kbd_in = 1'b1;
                  nx_in  = axx_ff[15];
                  ny_in  = axy_ff[15];
                  ax_in  = axx_ff[15] ? AX_W'(17'h10000 - {1'b0, axx_ff}) : AX_W'(axx_ff);
                  ay_in  = axy_ff[15] ? AX_W'(17'h10000 - {1'b0, axy_ff}) : AX_W'(axy_ff);
                  state_in = ST_SQX;
               end
               default: begin
                  if (!(hit0 || hit1)) begin
                     out_s_in   = 1'b0;
                     out_chg_in = 1'b0;
                  end else if (mode_ff == MODE_END) begin
                     out_s_in       = own_s;
                     out_chg_in     = 1'b1;
                     act_in[own_s]  = 1'b0;
                     fng_in[own_s]  = '0;
                     spr_in[own_s]  = 1'b0;
                     svx_in[own_s]  = '0;
                     svy_in[own_s]  = '0;
                     smag_in[own_s] = '0;
                  end else begin
                     s_in   = own_s;
                     kbd_in = 1'b0;
                     nx_in  = tx_ff < org_x;
                     ny_in  = ty_ff < org_y;
                     ax_in  = (tx_ff < org_x) ? AX_W'(org_x - tx_ff) : AX_W'(tx_ff - org_x);
                     ay_in  = (ty_ff < org_y) ? AX_W'(org_y - ty_ff) : AX_W'(ty_ff - org_y);
                     state_in = ST_SQX;
                  end
               end
            endcase
         end
         ST_SQX: begin
            sqx_in   = prod[SQ_W-1:0];
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sqy_in   = prod[SQ_W-1:0];
            state_in = ST_DZ2;
         end
         ST_DZ2: begin
            dz2_in   = prod[R2_W-1:0];
            d2_in    = D2_W'(sqx_ff) + D2_W'(sqy_ff);
            state_in = ST_RR2;
         end
         ST_RR2: begin
            r2_in    = prod[R2_W-1:0];
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (kbd_ff) begin
               clamp_in = d2_ff > ONE_SQ;
               if (d2_ff > ONE_SQ) begin
                  state_in = ST_DIVX;
               end else begin
                  vx_in    = axx_ff;
                  vy_in    = axy_ff;
                  state_in = ST_SQTM;
               end
            end else if (d2_ff < D2_W'(dz2_ff)) begin
               // dead zone: zero and released
               vx_in    = '0;
               vy_in    = '0;
               mag_in   = '0;
               pr_in    = 1'b0;
               state_in = ST_WRB;
            end else begin
               pr_in    = 1'b1;
               clamp_in = d2_ff > D2_W'(r2_ff);
               state_in = ST_DIVX;
            end
         end
         ST_DIVX, ST_SQTX, ST_DIVY, ST_SQTY, ST_DIVM, ST_SQTM: begin
            if (!issued_ff) begin
               a_start   = 1'b1;
               issued_in = 1'b1;
            end else if (a_rsp.done) begin
               issued_in = 1'b0;
               case (state_ff)
                  ST_DIVX: begin
                     if (clamp_ff) begin
                        state_in = ST_SQTX;
                     end else begin
                        vx_in    = sat_q15(a_res, nx_ff);
                        state_in = ST_DIVY;
                     end
                  end
                  ST_SQTX: begin
                     vx_in    = sat_q15(a_res, nx_ff);
                     state_in = ST_DIVY;
                  end
                  ST_DIVY: begin
                     if (clamp_ff) begin
                        state_in = ST_SQTY;
                     end else begin
                        vy_in    = sat_q15(a_res, ny_ff);
                        state_in = ST_DIVM;
                     end
                  end
                  ST_SQTY: begin
                     vy_in    = sat_q15(a_res, ny_ff);
                     mag_in   = ONE_Q15;
                     state_in = kbd_ff ? ST_PLO : ST_WRB;
                  end
                  ST_DIVM: state_in = ST_SQTM;
                  default: begin
                     mag_in   = a_res[15:0];
                     state_in = kbd_ff ? ST_PLO : ST_WRB;
                  end
               endcase
            end
         end
         ST_PLO: begin
            plo_in   = prod;
            state_in = ST_PHI;
         end
         ST_PHI: begin
            phi_in   = prod;
            state_in = ST_PCMP;
         end
         ST_PCMP: begin
            pr_in    = acc > thr;
            state_in = ST_WRB;
         end
         ST_WRB: begin
            svx_in[s_ff]  = vx_ff;
            svy_in[s_ff]  = vy_ff;
            smag_in[s_ff] = mag_ff;
            spr_in[s_ff]  = pr_ff;
            out_s_in      = s_ff;
            out_chg_in    = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_v_in = rsp_v_ff;
      if (rsp_load) begin
         rsp_v_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         act_ff    <= '0;
         spr_ff    <= '0;
         for (int i = 0; i < 2; i++) begin
            fng_ff[i]  <= '0;
            orgx_ff[i] <= '0;
            orgy_ff[i] <= '0;
            svx_ff[i]  <= '0;
            svy_ff[i]  <= '0;
            smag_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         rsp_v_ff  <= rsp_v_in;
         act_ff    <= act_in;
         spr_ff    <= spr_in;
         fng_ff    <= fng_in;
         orgx_ff   <= orgx_in;
         orgy_ff   <= orgy_in;
         svx_ff    <= svx_in;
         svy_ff    <= svy_in;
         smag_ff   <= smag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         mode_ff <= req_ch.mode;
         fid_ff  <= req_ch.finger_id;
         tx_ff   <= req_ch.touch_x;
         ty_ff   <= req_ch.touch_y;
         axx_ff  <= req_ch.axis_x;
         axy_ff  <= req_ch.axis_y;
         rs_ff   <= req_ch.right_stick;
      end
      s_ff       <= s_in;
      kbd_ff     <= kbd_in;
      clamp_ff   <= clamp_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      d2_ff      <= d2_in;
      dz2_ff     <= dz2_in;
      r2_ff      <= r2_in;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      mag_ff     <= mag_in;
      pr_ff      <= pr_in;
      out_s_ff   <= out_s_in;
      out_chg_ff <= out_chg_in;
      if (rsp_load) begin
         rsp_stick_ff <= out_s_ff;
         rsp_chg_ff   <= out_chg_ff;
         rsp_vx_ff    <= out_chg_ff ? svx_ff[out_s_ff] : 16'd0;
         rsp_vy_ff    <= out_chg_ff ? svy_ff[out_s_ff] : 16'd0;
         rsp_mag_ff   <= out_chg_ff ? smag_ff[out_s_ff] : 16'd0;
         rsp_pr_ff    <= out_chg_ff ? spr_ff[out_s_ff] : 1'b0;
      end
   end

   assign rsp_ch.valid     = rsp_v_ff;
   assign rsp_ch.stick     = rsp_stick_ff;
   assign rsp_ch.changed   = rsp_chg_ff;
   assign rsp_ch.vec_x     = rsp_vx_ff;
   assign rsp_ch.vec_y     = rsp_vy_ff;
   assign rsp_ch.magnitude = rsp_mag_ff;
   assign rsp_ch.pressed   = rsp_pr_ff;

endmodule

// ----- design/djt_checker.sv -----
module djt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_changed,
   input logic [15:0] rsp_vec_x,
   input logic [15:0] rsp_vec_y,
   input logic [15:0] rsp_magnitude,
   input logic        rsp_pressed
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_magnitude) && $stable(rsp_vec_x))
      else $error("result changed while stalled");

   // one item at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   a_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_magnitude <= 16'h8000)
      else $error("magnitude above one");

   a_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_changed |-> rsp_vec_x == 16'd0 && rsp_vec_y == 16'd0
                                    && rsp_magnitude == 16'd0 && !rsp_pressed)
      else $error("ignored item carries a value");

endmodule

bind dual_touch_joystick_tracker_core djt_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_changed   (rsp_ch.changed),
   .rsp_vec_x     (rsp_ch.vec_x),
   .rsp_vec_y     (rsp_ch.vec_y),
   .rsp_magnitude (rsp_ch.magnitude),
   .rsp_pressed   (rsp_ch.pressed)
);
